/* src/pdcm_pkg.sv */
package pdcm_pkg;

   localparam int DEF_NUM_CHANNELS = 4;
   localparam int DEF_DUTY_FULL    = 1000;

   localparam logic [15:0] PERIOD_RESET      = 16'd30000;
   localparam logic [9:0]  UPPER_LIMIT_RESET = 10'd1000;
   localparam logic [9:0]  LOWER_LIMIT_RESET = 10'd0;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_CTRL_PERIOD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_AUX_PERIOD  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_UPPER_LIMIT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWER_LIMIT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CTRL_CH     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERT      = 3'd5;

   typedef enum logic [1:0] {
      CMD_SET  = 2'd0,
      CMD_UP   = 2'd1,
      CMD_DOWN = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_LOAD,
      OP_MUL_PULSE,
      OP_DIV,
      OP_UPDATE,
      OP_MUL_BACK,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_ITEM,
      COND_SKIP,
      COND_DIV_MORE,
      COND_OUT_FULL
   } cond_type;

   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_WAIT      = 3'd0;
   localparam step_type STEP_LOAD      = 3'd1;
   localparam step_type STEP_MUL_PULSE = 3'd2;
   localparam step_type STEP_DIV_PULSE = 3'd3;
   localparam step_type STEP_UPDATE    = 3'd4;
   localparam step_type STEP_MUL_BACK  = 3'd5;
   localparam step_type STEP_DIV_BACK  = 3'd6;
   localparam step_type STEP_EMIT      = 3'd7;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   // jump taken when cond holds, else fall through (the last step wraps to wait)
   function automatic uword_type ucode_rom(input step_type pc);
      uword_type w;
      unique case (pc)
         STEP_WAIT:      w = '{OP_WAIT,      COND_NO_ITEM,  STEP_WAIT};
         STEP_LOAD:      w = '{OP_LOAD,      COND_SKIP,     STEP_MUL_BACK};
         STEP_MUL_PULSE: w = '{OP_MUL_PULSE, COND_NEVER,    STEP_WAIT};
         STEP_DIV_PULSE: w = '{OP_DIV,       COND_DIV_MORE, STEP_DIV_PULSE};
         STEP_UPDATE:    w = '{OP_UPDATE,    COND_NEVER,    STEP_WAIT};
         STEP_MUL_BACK:  w = '{OP_MUL_BACK,  COND_NEVER,    STEP_WAIT};
         STEP_DIV_BACK:  w = '{OP_DIV,       COND_DIV_MORE, STEP_DIV_BACK};
         STEP_EMIT:      w = '{OP_EMIT,      COND_OUT_FULL, STEP_EMIT};
         default:        w = '{OP_WAIT,      COND_NO_ITEM,  STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

/* src/pwm_duty_compare_manager.sv */
// PWM compare manager for up to NUM_CHANNELS channels. Each item is one command (set duty,
// step up, step down, read) on one channel and gives one result item with the channel's
// compare value, its period, a changed flag and the duty read back. Duty is in units of
// 1/DUTY_FULL of the period. A small microcode program drives one 16x16 multiplier and a
// shared divider that retires two quotient bits per cycle. A set or step item runs the
// load, pulse multiply, pulse divide, update, back multiply, back divide and emit steps;
// a read item or an unknown channel skips from load to the back multiply, back divide
// and emit steps. The result item is loaded into the output register as the sequencer
// returns to the wait step, where the next item can be taken. While an earlier result
// still waits in the output register the emit step holds.
module pwm_duty_compare_manager
   import pdcm_pkg::*;
#(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int DUTY_FULL    = DEF_DUTY_FULL
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,  // duty[9:0], limit_mode[10], steps[26:11]
   input  logic [3:0]            req_tuser,  // cmd[1:0], channel[3:2]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // compare_value[15:0], period_value[31:16], changed[32], duty_readback[42:33]
   output logic [47:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,  // out_channel[1:0]
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DW        = $clog2(DUTY_FULL + 1);
   localparam int NW        = 16 + DW;
   localparam int DIV_STEPS = (NW + 1) / 2;
   localparam int QW        = 2 * DIV_STEPS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic [DW-1:0] FULL_D   = DW'(DUTY_FULL);
   localparam logic [15:0]   FULL_16  = 16'(DUTY_FULL);
   localparam logic [QW-1:0] FULL_Q   = QW'(DUTY_FULL);
   localparam logic [4:0]    NCH_5    = 5'(NUM_CHANNELS);

   // configuration
   logic [15:0]  ctrl_period_ff, aux_period_ff;
   logic [9:0]   upper_ff, lower_ff;
   logic [1:0]   ctrl_ch_ff;
   logic         invert_ff;

   // sequencer
   step_type     pc_ff, pc_in;
   uword_type    uw;
   logic         take;

   // item
   cmd_type      cmd_ff;
   logic [1:0]   ch_ff;
   logic [9:0]   duty_ff;
   logic         limit_ff;
   logic [15:0]  steps_ff;

   // datapath
   logic [15:0]  old_ff, old_in;
   logic [15:0]  next_ff, next_in;
   logic [DW-1:0] mul_a_ff, mul_a_in;
   logic [15:0]  rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [15:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic         changed_ff, changed_in;
   logic [15:0]  pulse_ff [NUM_CHANNELS];
   logic [15:0]  pulse_in;
   logic         pulse_wr;

   // output register
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]   rsp_tuser_ff, rsp_tuser_in;

   // combinational helpers
   logic         req_fire, out_full, emit_go;
   logic         is_ctrl, inv, ch_valid, skip;
   logic [CH_IDX_W-1:0] idx;
   logic [15:0]  period;
   logic [DW-1:0] upper_c, lower_c, set_duty;
   logic [15:0]  mul_x, mul_y;
   logic [31:0]  mul_p;
   logic [15:0]  div_rem;
   logic [QW-1:0] div_quo;
   logic [16:0]  div_trial;
   logic [16:0]  up_sum, down_sum;
   logic [15:0]  upd;
   logic [DW-1:0] back;

   function automatic logic [DW-1:0] cap_full(input logic [9:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'(DUTY_FULL)) ? FULL_D : DW'(v);
   endfunction

   assign uw         = ucode_rom(pc_ff);
   assign req_tready = (uw.op == OP_WAIT);
   assign req_fire   = req_tvalid && req_tready;
   assign out_full   = rsp_tvalid_ff && !rsp_tready;
   assign emit_go    = (uw.op == OP_EMIT) && !out_full;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign is_ctrl  = (ch_ff == ctrl_ch_ff);
   assign inv      = is_ctrl && invert_ff;
   assign ch_valid = (5'(ch_ff) < NCH_5);
   assign idx      = CH_IDX_W'(ch_ff);
   assign skip     = !ch_valid || (cmd_ff == CMD_READ);
   assign upper_c  = cap_full(upper_ff);
   assign lower_c  = cap_full(lower_ff);

   always_comb begin
      logic [15:0] raw;
      raw    = is_ctrl ? ctrl_period_ff : aux_period_ff;
      period = (raw == 16'd0) ? 16'd1 : raw;
   end

   // set duty: invert, then in limit mode clamp upper, then lower
   always_comb begin
      set_duty = cap_full(duty_ff);
      if (inv) begin
         set_duty = FULL_D - set_duty;
      end
      if (limit_ff) begin
         if (set_duty > upper_c) begin
            set_duty = upper_c;
         end
         if (set_duty < lower_c) begin
            set_duty = lower_c;
         end
      end
   end

   // shared multiplier
   assign mul_x = (uw.op == OP_MUL_BACK) ? next_ff : 16'(mul_a_ff);
   assign mul_y = (uw.op == OP_MUL_BACK) ? FULL_16 : period;
   assign mul_p = mul_x * mul_y;

   // two restoring divide steps
   always_comb begin
      div_rem   = rem_ff;
      div_quo   = quo_ff;
      div_trial = '0;
      for (int i = 0; i < 2; i++) begin
         div_trial = {div_rem, div_quo[QW-1]};
         div_quo   = {div_quo[QW-2:0], 1'b0};
         if (div_trial >= {1'b0, dsr_ff}) begin
            div_trial  = div_trial - {1'b0, dsr_ff};
            div_quo[0] = 1'b1;
         end
         div_rem = div_trial[15:0];
      end
   end

   // new pulse: the divided set value, or the old pulse stepped and bounded by the divided limit
   assign up_sum   = {1'b0, old_ff} + {1'b0, steps_ff};
   assign down_sum = {1'b0, quo_ff[15:0]} + {1'b0, steps_ff};

   always_comb begin
      unique case (cmd_ff)
         CMD_SET:  upd = quo_ff[15:0];
         CMD_UP:   upd = ({1'b0, quo_ff[15:0]} > up_sum) ? up_sum[15:0] : quo_ff[15:0];
         CMD_DOWN: upd = (down_sum < {1'b0, old_ff}) ? (old_ff - steps_ff) : quo_ff[15:0];
         CMD_READ: upd = old_ff;
         default:  upd = old_ff;
      endcase
   end

   always_comb begin
      back = (quo_ff > FULL_Q) ? FULL_D : DW'(quo_ff);
      if (inv) begin
         back = FULL_D - back;
      end
   end

   // sequencer
   always_comb begin
      unique case (uw.cond)
         COND_NEVER:    take = 1'b0;
         COND_NO_ITEM:  take = !req_fire;
         COND_SKIP:     take = skip;
         COND_DIV_MORE: take = (cnt_ff != CNT_W'(1));
         COND_OUT_FULL: take = out_full;
         default:       take = 1'b0;
      endcase
      pc_in = take ? uw.target : pc_ff + STEP_W'(1);
   end

   // datapath next values
   always_comb begin
      old_in        = old_ff;
      next_in       = next_ff;
      mul_a_in      = mul_a_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dsr_in        = dsr_ff;
      cnt_in        = cnt_ff;
      changed_in    = changed_ff;
      pulse_in      = upd;
      pulse_wr      = 1'b0;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      unique case (uw.op)
         OP_LOAD: begin
            old_in     = ch_valid ? pulse_ff[idx] : 16'd0;
            next_in    = old_in;
            changed_in = 1'b0;
            unique case (cmd_ff)
               CMD_SET:  mul_a_in = set_duty;
               CMD_UP:   mul_a_in = upper_c;
               default:  mul_a_in = lower_c;
            endcase
         end
         OP_MUL_PULSE: begin
            quo_in = QW'(mul_p);
            rem_in = '0;
            dsr_in = FULL_16;
            cnt_in = CNT_W'(DIV_STEPS);
         end
         OP_MUL_BACK: begin
            quo_in = QW'(mul_p);
            rem_in = '0;
            dsr_in = period;
            cnt_in = CNT_W'(DIV_STEPS);
         end
         OP_DIV: begin
            quo_in = div_quo;
            rem_in = div_rem;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_UPDATE: begin
            next_in    = upd;
            changed_in = (upd != old_ff);
            pulse_wr   = (upd != old_ff);
         end
         OP_EMIT: begin
            if (emit_go) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = ch_ff;
               rsp_tdata_in  = {5'd0, 10'(back), changed_ff, period, next_ff};
            end
         end
         OP_WAIT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= STEP_WAIT;
         cnt_ff         <= '0;
         changed_ff     <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
         ctrl_period_ff <= PERIOD_RESET;
         aux_period_ff  <= PERIOD_RESET;
         upper_ff       <= UPPER_LIMIT_RESET;
         lower_ff       <= LOWER_LIMIT_RESET;
         ctrl_ch_ff     <= 2'd0;
         invert_ff      <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pulse_ff[i] <= 16'd0;
         end
      end else begin
         pc_ff         <= pc_in;
         cnt_ff        <= cnt_in;
         changed_ff    <= changed_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (pulse_wr) begin
            pulse_ff[idx] <= pulse_in;
         end
         if (csr_wr_en) begin
            unique case (csr_addr)
               CSR_CTRL_PERIOD: ctrl_period_ff <= csr_wdata;
               CSR_AUX_PERIOD:  aux_period_ff  <= csr_wdata;
               CSR_UPPER_LIMIT: upper_ff       <= csr_wdata[9:0];
               CSR_LOWER_LIMIT: lower_ff       <= csr_wdata[9:0];
               CSR_CTRL_CH:     ctrl_ch_ff     <= csr_wdata[1:0];
               CSR_INVERT:      invert_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      if (req_fire) begin
         cmd_ff   <= cmd_type'(req_tuser[1:0]);
         ch_ff    <= req_tuser[3:2];
         duty_ff  <= req_tdata[9:0];
         limit_ff <= req_tdata[10];
         steps_ff <= req_tdata[26:11];
      end
      old_ff       <= old_in;
      next_ff      <= next_in;
      mul_a_ff     <= mul_a_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dsr_ff       <= dsr_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_DIV_PULSE || pc_ff == STEP_DIV_BACK) |-> rem_ff < dsr_ff)
      else $error("divider remainder not below divisor");

   // changed flag only raised by the update step
   a_changed_src: assert property (@(posedge clock) disable iff (reset)
      $rose(changed_ff) |-> $past(pc_ff) == STEP_UPDATE)
      else $error("changed flag raised outside update step");

   // a stalled result keeps the sequencer at the emit step
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_EMIT && rsp_tvalid_ff && !rsp_tready) |=> pc_ff == STEP_EMIT)
      else $error("emit step left while output register full");

   // an accepted item starts at the load step
   a_ready_wait: assert property (@(posedge clock) disable iff (reset)
      (req_fire) |=> pc_ff == STEP_LOAD)
      else $error("accepted item did not start at load step");

endmodule

/* sim/tb_pwm_duty_compare_manager.sv */
`timescale 1ns / 1ps

module tb_pwm_duty_compare_manager;
   import pdcm_pkg::*;

   localparam int NUM_CH        = DEF_NUM_CHANNELS;
   localparam int FULL          = DEF_DUTY_FULL;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [1:0]  channel;
      logic [15:0] compare;
      logic [15:0] period;
      logic        changed;
      logic [9:0]  readback;
   } compare_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;
   logic [3:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [47:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // mirror of the block's registers and compare store
   logic [15:0] ctrl_period_m;
   logic [15:0] aux_period_m;
   logic [9:0]  upper_m;
   logic [9:0]  lower_m;
   logic [1:0]  ctrl_ch_m;
   logic        invert_m;
   logic [15:0] pulse_m [NUM_CH];

   compare_result_type pending_compares[$];
   compare_result_type oldest_compare;
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int hold_left      = 0;

   always #5 clock = ~clock;

   pwm_duty_compare_manager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic logic [31:0] cap_full(input logic [31:0] v);
      return (v > FULL) ? FULL : v;
   endfunction

   function automatic logic [31:0] duty_to_counts(input logic [31:0] duty,
                                                  input logic [31:0] period);
      return (duty * period) / FULL;
   endfunction

   function automatic compare_result_type compute_compare_result(input cmd_type op,
         input logic [1:0] ch, input logic [9:0] duty_in, input logic limit_mode,
         input logic [15:0] steps);
      compare_result_type r;
      logic [31:0] duty, period, upper, lower, old_p, nxt_p, bound, back;
      logic is_ctrl, inv, ok, chg;
      duty    = cap_full(32'(duty_in));
      is_ctrl = (ch == ctrl_ch_m);
      inv     = is_ctrl && invert_m;
      period  = is_ctrl ? 32'(ctrl_period_m) : 32'(aux_period_m);
      if (period == 0)
         period = 1;
      upper = cap_full(32'(upper_m));
      lower = cap_full(32'(lower_m));
      ok    = (ch < NUM_CH);
      old_p = ok ? 32'(pulse_m[ch]) : 32'd0;
      nxt_p = old_p;
      chg   = 1'b0;
      if (ok) begin
         case (op)
            CMD_SET: begin
               if (inv)
                  duty = FULL - duty;
               if (limit_mode) begin
                  if (duty > upper)
                     duty = upper;
                  if (duty < lower)
                     duty = lower;
               end
               nxt_p = duty_to_counts(duty, period);
            end
            CMD_UP: begin
               bound = duty_to_counts(upper, period);
               nxt_p = (bound > old_p + 32'(steps)) ? old_p + 32'(steps) : bound;
            end
            CMD_DOWN: begin
               bound = duty_to_counts(lower, period);
               nxt_p = (bound + 32'(steps) < old_p) ? old_p - 32'(steps) : bound;
            end
            default: ;
         endcase
         nxt_p = nxt_p & 32'hFFFF;
         if (nxt_p != old_p) begin
            pulse_m[ch] = nxt_p[15:0];
            chg = 1'b1;
         end
      end
      back = cap_full((nxt_p * FULL) / period);
      if (inv)
         back = FULL - back;
      r.channel  = ch;
      r.compare  = nxt_p[15:0];
      r.period   = period[15:0];
      r.changed  = chg;
      r.readback = back[9:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic send_command(input cmd_type op, input logic [1:0] ch,
         input logic [9:0] duty, input logic limit_mode, input logic [15:0] steps);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {ch, op};
      req_tdata  <= {5'd0, steps, limit_mode, duty};
      @(posedge clock iff req_tready);
      pending_compares.push_back(compute_compare_result(op, ch, duty, limit_mode, steps));
   endtask

   task automatic send_random_command();
      logic [15:0] steps;
      logic [9:0]  duty;
      case ($urandom_range(7))
         0: steps = 16'hFFFF;
         1: steps = 16'd0;
         2: steps = 16'($urandom);
         3, 4: steps = 16'($urandom_range(300));
         default: steps = 16'($urandom_range(5000));
      endcase
      duty = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(FULL));
      send_command(cmd_type'(2'($urandom_range(3))), 2'($urandom_range(3)), duty,
                   1'($urandom_range(1)), steps);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_compares.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (addr)
         CSR_CTRL_PERIOD: ctrl_period_m = data;
         CSR_AUX_PERIOD:  aux_period_m  = data;
         CSR_UPPER_LIMIT: upper_m       = data[9:0];
         CSR_LOWER_LIMIT: lower_m       = data[9:0];
         CSR_CTRL_CH:     ctrl_ch_m     = data[1:0];
         CSR_INVERT:      invert_m      = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] ctrl_p, input logic [15:0] aux_p,
         input logic [9:0] upper, input logic [9:0] lower, input logic [1:0] ctrl_ch,
         input logic inv);
      write_csr(CSR_CTRL_PERIOD, ctrl_p);
      write_csr(CSR_AUX_PERIOD, aux_p);
      write_csr(CSR_UPPER_LIMIT, {6'd0, upper});
      write_csr(CSR_LOWER_LIMIT, {6'd0, lower});
      write_csr(CSR_CTRL_CH, {14'd0, ctrl_ch});
      write_csr(CSR_INVERT, {15'd0, inv});
   endtask

   function automatic logic [15:0] pick_period();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3: return 16'($urandom_range(50, 1));
         default: return 16'($urandom_range(65535, 1));
      endcase
   endfunction

   function automatic logic [9:0] pick_limit();
      case ($urandom_range(9))
         0: return 10'd0;
         1: return 10'd1000;
         2: return 10'd1023;
         3: return 10'($urandom_range(1023, 1001));
         default: return 10'($urandom_range(FULL));
      endcase
   endfunction

   task automatic test_reset_state();
      for (int ch = 0; ch < NUM_CH; ch++)
         send_command(CMD_READ, 2'(ch), 10'd0, 1'b0, 16'd0);
      send_command(CMD_SET, 2'd0, 10'd1000, 1'b0, 16'd0);
      send_command(CMD_SET, 2'd1, 10'd1023, 1'b0, 16'hFFFF);
      send_command(CMD_SET, 2'd2, 10'd0, 1'b1, 16'd0);
      send_command(CMD_UP, 2'd3, 10'd1023, 1'b1, 16'hFFFF);
      send_command(CMD_DOWN, 2'd3, 10'd0, 1'b0, 16'd0);
      send_command(CMD_DOWN, 2'd1, 10'd0, 1'b0, 16'hFFFF);
      send_command(CMD_READ, 2'd0, 10'd0, 1'b0, 16'd0);
      wait_for_results();
   endtask

   task automatic test_limits_and_inversion();
      apply_settings(16'd12345, 16'd30000, 10'd700, 10'd200, 2'd1, 1'b1);
      send_command(CMD_SET, 2'd1, 10'd100, 1'b1, 16'd0);
      send_command(CMD_SET, 2'd1, 10'd950, 1'b0, 16'd0);
      send_command(CMD_READ, 2'd1, 10'd0, 1'b0, 16'd0);
      // pulse above the step-up bound, pulse below the step-down bound
      send_command(CMD_UP, 2'd0, 10'd0, 1'b0, 16'd0);
      send_command(CMD_DOWN, 2'd2, 10'd0, 1'b0, 16'd0);
      wait_for_results();
      // crossed limits
      apply_settings(16'd12345, 16'd30000, 10'd100, 10'd900, 2'd1, 1'b1);
      send_command(CMD_SET, 2'd2, 10'd500, 1'b1, 16'd0);
      wait_for_results();
      // both limits above full scale
      apply_settings(16'd40000, 16'd65535, 10'd1023, 10'd1023, 2'd3, 1'b0);
      send_command(CMD_SET, 2'd3, 10'd0, 1'b1, 16'd0);
      send_command(CMD_DOWN, 2'd3, 10'd0, 1'b0, 16'd5);
      wait_for_results();
      // zero periods
      apply_settings(16'd0, 16'd0, 10'd1000, 10'd0, 2'd2, 1'b0);
      send_command(CMD_SET, 2'd2, 10'd1000, 1'b0, 16'd0);
      send_command(CMD_READ, 2'd0, 10'd0, 1'b0, 16'd0);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 49; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         for (int k = 0; k < 7; k++) begin
            if (k == 0)
               apply_settings(16'd1, 16'd1, 10'd0, 10'd0, 2'd0, 1'b0);
            else if (k == 1)
               apply_settings(16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023, 2'd3, 1'b1);
            else
               apply_settings(pick_period(), pick_period(), pick_limit(), pick_limit(),
                              2'($urandom_range(3)), 1'($urandom_range(1)));
            repeat (50) send_random_command();
            wait_for_results();
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   task automatic test_output_backpressure();
      apply_settings(16'd30000, 16'd20000, 10'd900, 10'd100, 2'd1, 1'b1);
      hold_left <= HOLD_CYCLES;
      repeat (30) send_random_command();
      wait_for_results();
   endtask

   task automatic test_pause_until_idle();
      send_idle_pct = 18;
      stall_pct     = 18;
      repeat (20) send_random_command();
      wait_for_results();
      repeat (20) send_random_command();
      wait_for_results();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_compares.size() == 0) begin
            report_mismatch("result item with nothing pending", rsp_tdata[31:0], 32'd0);
         end else begin
            oldest_compare = pending_compares.pop_front();
            if (rsp_tuser !== oldest_compare.channel)
               report_mismatch("out_channel", 32'(rsp_tuser),
                               32'(oldest_compare.channel));
            if (rsp_tdata[15:0] !== oldest_compare.compare)
               report_mismatch("compare_value", 32'(rsp_tdata[15:0]),
                               32'(oldest_compare.compare));
            if (rsp_tdata[31:16] !== oldest_compare.period)
               report_mismatch("period_value", 32'(rsp_tdata[31:16]),
                               32'(oldest_compare.period));
            if (rsp_tdata[32] !== oldest_compare.changed)
               report_mismatch("changed", 32'(rsp_tdata[32]),
                               32'(oldest_compare.changed));
            if (rsp_tdata[42:33] !== oldest_compare.readback)
               report_mismatch("duty_readback", 32'(rsp_tdata[42:33]),
                               32'(oldest_compare.readback));
         end
      end
   end

   initial begin
      ctrl_period_m = PERIOD_RESET;
      aux_period_m  = PERIOD_RESET;
      upper_m       = UPPER_LIMIT_RESET;
      lower_m       = LOWER_LIMIT_RESET;
      ctrl_ch_m     = 2'd0;
      invert_m      = 1'b0;
      for (int i = 0; i < NUM_CH; i++)
         pulse_m[i] = 16'd0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 32'd0;
      req_tuser  <= 4'd0;
      rsp_tready <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_limits_and_inversion();
      test_random_traffic();
      test_output_backpressure();
      test_pause_until_idle();
      wait_for_results();
      if (mismatch_count == 0 && pending_compares.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
